>>> hdl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: shared definitions
// Widths, request and event codes, sequencer states and the control structs
// passed between the list, the compare unit and the sequencer.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int ID_W       = 4;
    localparam int NUM_TIMERS = 1 << ID_W;
    localparam int CNT_W      = ID_W + 1;
    localparam int TICK_W     = 32;
    localparam int LEAD_W     = 16;
    localparam int EV_W       = 3;

    localparam logic [CNT_W-1:0]  MAX_RES    = CNT_W'(16);
    localparam logic [LEAD_W-1:0] LEAD_RESET = LEAD_W'(8);

    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_SERVICE  = 2'd2,
        KIND_REARM    = 2'd3
    } kind_t;

    typedef enum logic [EV_W-1:0] {
        EV_QUEUED    = 3'd0,
        EV_REJECTED  = 3'd1,
        EV_CANCELLED = 3'd2,
        EV_EXPIRED   = 3'd3,
        EV_NONE      = 3'd4
    } event_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CAN_RD,
        S_FIND,
        S_WALK_RD,
        S_WALK_CMP,
        S_PLACE,
        S_HEAD,
        S_HEAD_WAIT,
        S_SVC_RD,
        S_SVC_CMP,
        S_SVC_ERD,
        S_SVC_EMIT,
        S_POP,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        LIST_NOP,
        LIST_INSERT,
        LIST_REMOVE
    } list_op_t;

    typedef struct packed {
        list_op_t        op;
        logic [ID_W-1:0] pos;
        logic [ID_W-1:0] id;
    } list_ctrl_t;

    typedef struct packed {
        logic neg;
        logic zero;
        logic lt_lead;
        logic lt_cmp;
    } alu_flags_t;

endpackage

>>> hdl/sdtq_alu.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: shared compare unit
// One wrapping subtraction with its sign, zero, lead and signed compare flags.
// ----------------------------------------------------------------------------
module sdtq_alu
(
    input  logic [sdtq_pkg::TICK_W-1:0] a,
    input  logic [sdtq_pkg::TICK_W-1:0] b,
    input  logic [sdtq_pkg::TICK_W-1:0] cmp_diff,
    input  logic [sdtq_pkg::LEAD_W-1:0] lead,
    output logic [sdtq_pkg::TICK_W-1:0] diff,
    output sdtq_pkg::alu_flags_t        flags
);

    assign diff          = a - b;
    assign flags.neg     = diff[sdtq_pkg::TICK_W-1];
    assign flags.zero    = (diff == '0);
    assign flags.lt_lead = (diff < {{(sdtq_pkg::TICK_W-sdtq_pkg::LEAD_W){1'b0}}, lead});
    assign flags.lt_cmp  = ($signed(diff) < $signed(cmp_diff));

endmodule

>>> hdl/sdtq_ram.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: deadline memory
// Single write port and single registered read port.
// ----------------------------------------------------------------------------
module sdtq_ram
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/sdtq_list.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: ordered list
// Timer ids in deadline order, pending flags and the fill count, with
// registered insert and remove at a position.
// ----------------------------------------------------------------------------
module sdtq_list
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sdtq_pkg::list_ctrl_t         ctrl,
    input  logic [sdtq_pkg::ID_W-1:0]    rd_idx,
    input  logic [sdtq_pkg::ID_W-1:0]    q_id,
    output logic [sdtq_pkg::ID_W-1:0]    rd_id,
    output logic [sdtq_pkg::CNT_W-1:0]   count,
    output logic                         pend
);

    logic [sdtq_pkg::ID_W-1:0]       order_reg   [sdtq_pkg::NUM_TIMERS];
    logic [sdtq_pkg::ID_W-1:0]       order_next  [sdtq_pkg::NUM_TIMERS];
    logic [sdtq_pkg::NUM_TIMERS-1:0] pending_reg;
    logic [sdtq_pkg::NUM_TIMERS-1:0] pending_next;
    logic [sdtq_pkg::CNT_W-1:0]      count_reg;
    logic [sdtq_pkg::CNT_W-1:0]      count_next;

    always_comb
    begin
        order_next   = order_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        case (ctrl.op)
            sdtq_pkg::LIST_INSERT:
            begin
                for (int q = 1; q < sdtq_pkg::NUM_TIMERS; q++)
                begin
                    if (q > int'(ctrl.pos))
                    begin
                        order_next[q] = order_reg[q-1];
                    end
                end
                order_next[ctrl.pos]   = ctrl.id;
                pending_next[ctrl.id]  = 1'b1;
                count_next             = count_reg + sdtq_pkg::CNT_W'(1);
            end
            sdtq_pkg::LIST_REMOVE:
            begin
                for (int q = 0; q < sdtq_pkg::NUM_TIMERS - 1; q++)
                begin
                    if (q >= int'(ctrl.pos))
                    begin
                        order_next[q] = order_reg[q+1];
                    end
                end
                pending_next[order_reg[ctrl.pos]] = 1'b0;
                count_next = count_reg - sdtq_pkg::CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
    end

    assign rd_id = order_reg[rd_idx];
    assign count = count_reg;
    assign pend  = pending_reg[q_id];

endmodule

>>> hdl/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Up to sixteen pending timers kept in due order, with schedule, cancel,
// service and rearm requests handled by a small sequencer.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (kind, timer_id, due_tick, now_tick) and
// are taken when req_valid is high and req_stall is low. Results leave on the
// res channel; each carries the head deadline left after the whole request,
// and last marks the final result of a request. A service request gives one
// result per expired timer, at most sixteen, or one EV_NONE result if none
// has expired; the other requests give one. min_lead_ticks is written through
// the cfg channel; the user must do this only while the block is idle, since
// the block itself does not enforce it. One shared subtractor and comparator
// serves every deadline comparison, and deadline reads go through a memory
// with a registered read port. A schedule or rearm drops any old copy of the
// timer, then walks past the entries due before it; a cancel only drops; a
// service finds the expired timers, gives their results, then removes them.
// req_stall stays high for the whole of a request. A finished result sits in
// an output register, so the next request is taken while the receiver stalls,
// and it waits there until res_stall is low. Reset empties the queue with no
// clearing pass and sets min_lead_ticks to 8.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    kind,
    input  logic [sdtq_pkg::ID_W-1:0]     timer_id,
    input  logic [sdtq_pkg::TICK_W-1:0]   due_tick,
    input  logic [sdtq_pkg::TICK_W-1:0]   now_tick,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sdtq_pkg::EV_W-1:0]     event_res,
    output logic [sdtq_pkg::ID_W-1:0]     out_timer_id,
    output logic [sdtq_pkg::TICK_W-1:0]   out_due_tick,
    output logic                          head_valid,
    output logic [sdtq_pkg::TICK_W-1:0]   head_due_tick,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdtq_pkg::LEAD_W-1:0]   cfg_data
);

    sdtq_pkg::state_t                 state_reg, state_next;
    logic [sdtq_pkg::CNT_W-1:0]       p_reg, p_next;
    logic [sdtq_pkg::CNT_W-1:0]       k_reg, k_next;
    logic                             res_valid_reg, res_valid_next;
    logic [sdtq_pkg::LEAD_W-1:0]      lead_reg;

    sdtq_pkg::kind_t                  kind_reg, kind_next;
    logic [sdtq_pkg::ID_W-1:0]        id_reg, id_next;
    logic [sdtq_pkg::TICK_W-1:0]      due_reg, due_next;
    logic [sdtq_pkg::TICK_W-1:0]      now_reg, now_next;
    logic [sdtq_pkg::TICK_W-1:0]      hd_reg, hd_next;
    logic                             duef_reg, duef_next;
    logic [sdtq_pkg::EV_W-1:0]        ev_reg, ev_next;
    logic [sdtq_pkg::TICK_W-1:0]      rdue_reg, rdue_next;
    logic                             hv_reg, hv_next;
    logic [sdtq_pkg::TICK_W-1:0]      hdue_reg, hdue_next;

    logic [sdtq_pkg::EV_W-1:0]        res_event_reg;
    logic [sdtq_pkg::ID_W-1:0]        res_id_reg;
    logic [sdtq_pkg::TICK_W-1:0]      res_due_reg;
    logic                             res_hv_reg;
    logic [sdtq_pkg::TICK_W-1:0]      res_hdue_reg;
    logic                             res_last_reg;

    logic                             load;
    logic [sdtq_pkg::EV_W-1:0]        ld_event;
    logic [sdtq_pkg::ID_W-1:0]        ld_id;
    logic [sdtq_pkg::TICK_W-1:0]      ld_due;
    logic                             ld_last;
    logic                             out_free;

    sdtq_pkg::list_ctrl_t             list_ctrl;
    logic [sdtq_pkg::ID_W-1:0]        rd_idx;
    logic [sdtq_pkg::ID_W-1:0]        rd_id;
    logic [sdtq_pkg::CNT_W-1:0]       count;
    logic                             pend;
    logic [sdtq_pkg::CNT_W-1:0]       hidx;

    logic                             wr_en;
    logic [sdtq_pkg::ID_W-1:0]        wr_addr;
    logic [sdtq_pkg::TICK_W-1:0]      wr_data;
    logic [sdtq_pkg::ID_W-1:0]        rd_addr;
    logic [sdtq_pkg::TICK_W-1:0]      rd_data;

    logic [sdtq_pkg::TICK_W-1:0]      alu_a;
    logic [sdtq_pkg::TICK_W-1:0]      alu_b;
    logic [sdtq_pkg::TICK_W-1:0]      alu_diff;
    sdtq_pkg::alu_flags_t             alu_flags;

    sdtq_list u_list
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (list_ctrl),
        .rd_idx (rd_idx),
        .q_id   (id_reg),
        .rd_id  (rd_id),
        .count  (count),
        .pend   (pend)
    );

    sdtq_ram
    #(
        .DEPTH (sdtq_pkg::NUM_TIMERS),
        .WIDTH (sdtq_pkg::TICK_W)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sdtq_alu u_alu
    (
        .a        (alu_a),
        .b        (alu_b),
        .cmp_diff (hd_reg),
        .lead     (lead_reg),
        .diff     (alu_diff),
        .flags    (alu_flags)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = (state_reg != sdtq_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        kind_next  = kind_reg;
        id_next    = id_reg;
        due_next   = due_reg;
        now_next   = now_reg;
        hd_next    = hd_reg;
        duef_next  = duef_reg;
        ev_next    = ev_reg;
        rdue_next  = rdue_reg;
        hv_next    = hv_reg;
        hdue_next  = hdue_reg;

        list_ctrl.op  = sdtq_pkg::LIST_NOP;
        list_ctrl.pos = p_reg[sdtq_pkg::ID_W-1:0];
        list_ctrl.id  = id_reg;
        rd_idx        = p_reg[sdtq_pkg::ID_W-1:0];
        rd_addr       = rd_id;
        wr_en         = 1'b0;
        wr_addr       = id_reg;
        wr_data       = due_reg;
        alu_a         = due_reg;
        alu_b         = now_reg;

        load     = 1'b0;
        ld_event = ev_reg;
        ld_id    = id_reg;
        ld_due   = rdue_reg;
        ld_last  = 1'b1;

        hidx = (kind_reg == sdtq_pkg::KIND_SERVICE) ? p_reg : '0;

        case (state_reg)
            sdtq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = sdtq_pkg::kind_t'(kind);
                    id_next    = timer_id;
                    due_next   = due_tick;
                    now_next   = now_tick;
                    p_next     = '0;
                    k_next     = '0;
                    state_next = sdtq_pkg::S_START;
                end
            end
            sdtq_pkg::S_START:
            begin
                hd_next   = alu_diff;
                duef_next = alu_flags.neg || alu_flags.lt_lead;
                case (kind_reg)
                    sdtq_pkg::KIND_SERVICE:
                    begin
                        ev_next    = sdtq_pkg::EV_NONE;
                        id_next    = '0;
                        rdue_next  = '0;
                        state_next = sdtq_pkg::S_SVC_RD;
                    end
                    sdtq_pkg::KIND_CANCEL:
                    begin
                        ev_next   = sdtq_pkg::EV_CANCELLED;
                        rdue_next = '0;
                        rd_addr   = id_reg;
                        if (pend)
                        begin
                            state_next = sdtq_pkg::S_CAN_RD;
                        end
                        else
                        begin
                            state_next = sdtq_pkg::S_HEAD;
                        end
                    end
                    default:
                    begin
                        if (pend)
                        begin
                            state_next = sdtq_pkg::S_FIND;
                        end
                        else
                        begin
                            state_next = sdtq_pkg::S_WALK_RD;
                        end
                    end
                endcase
            end
            sdtq_pkg::S_CAN_RD:
            begin
                rdue_next  = rd_data;
                state_next = sdtq_pkg::S_FIND;
            end
            sdtq_pkg::S_FIND:
            begin
                if (p_reg == count || rd_id == id_reg)
                begin
                    if (p_reg != count)
                    begin
                        list_ctrl.op = sdtq_pkg::LIST_REMOVE;
                    end
                    p_next = '0;
                    if (kind_reg == sdtq_pkg::KIND_CANCEL)
                    begin
                        state_next = sdtq_pkg::S_HEAD;
                    end
                    else
                    begin
                        state_next = sdtq_pkg::S_WALK_RD;
                    end
                end
                else
                begin
                    p_next = p_reg + sdtq_pkg::CNT_W'(1);
                end
            end
            sdtq_pkg::S_WALK_RD:
            begin
                if (p_reg == count)
                begin
                    state_next = sdtq_pkg::S_PLACE;
                end
                else
                begin
                    state_next = sdtq_pkg::S_WALK_CMP;
                end
            end
            sdtq_pkg::S_WALK_CMP:
            begin
                if (kind_reg == sdtq_pkg::KIND_SCHEDULE)
                begin
                    alu_a = rd_data;
                    alu_b = now_reg;
                    if (alu_flags.lt_cmp)
                    begin
                        p_next     = p_reg + sdtq_pkg::CNT_W'(1);
                        state_next = sdtq_pkg::S_WALK_RD;
                    end
                    else
                    begin
                        state_next = sdtq_pkg::S_PLACE;
                    end
                end
                else
                begin
                    alu_a = due_reg;
                    alu_b = rd_data;
                    if (alu_flags.zero || alu_flags.neg)
                    begin
                        state_next = sdtq_pkg::S_PLACE;
                    end
                    else
                    begin
                        p_next     = p_reg + sdtq_pkg::CNT_W'(1);
                        state_next = sdtq_pkg::S_WALK_RD;
                    end
                end
            end
            sdtq_pkg::S_PLACE:
            begin
                rdue_next = due_reg;
                if (kind_reg == sdtq_pkg::KIND_SCHEDULE && p_reg == '0 && duef_reg)
                begin
                    ev_next = sdtq_pkg::EV_REJECTED;
                end
                else
                begin
                    ev_next      = sdtq_pkg::EV_QUEUED;
                    list_ctrl.op = sdtq_pkg::LIST_INSERT;
                    wr_en        = 1'b1;
                end
                state_next = sdtq_pkg::S_HEAD;
            end
            sdtq_pkg::S_HEAD:
            begin
                rd_idx = hidx[sdtq_pkg::ID_W-1:0];
                if (hidx >= count)
                begin
                    hv_next   = 1'b0;
                    hdue_next = '0;
                    if (kind_reg == sdtq_pkg::KIND_SERVICE && p_reg != '0)
                    begin
                        state_next = sdtq_pkg::S_SVC_ERD;
                    end
                    else
                    begin
                        state_next = sdtq_pkg::S_EMIT;
                    end
                end
                else
                begin
                    state_next = sdtq_pkg::S_HEAD_WAIT;
                end
            end
            sdtq_pkg::S_HEAD_WAIT:
            begin
                hv_next   = 1'b1;
                hdue_next = rd_data;
                if (kind_reg == sdtq_pkg::KIND_SERVICE && p_reg != '0)
                begin
                    state_next = sdtq_pkg::S_SVC_ERD;
                end
                else
                begin
                    state_next = sdtq_pkg::S_EMIT;
                end
            end
            sdtq_pkg::S_SVC_RD:
            begin
                if (p_reg == sdtq_pkg::MAX_RES || p_reg == count)
                begin
                    state_next = sdtq_pkg::S_HEAD;
                end
                else
                begin
                    state_next = sdtq_pkg::S_SVC_CMP;
                end
            end
            sdtq_pkg::S_SVC_CMP:
            begin
                alu_a = rd_data;
                alu_b = now_reg;
                if (alu_flags.neg || alu_flags.lt_lead)
                begin
                    p_next     = p_reg + sdtq_pkg::CNT_W'(1);
                    state_next = sdtq_pkg::S_SVC_RD;
                end
                else
                begin
                    state_next = sdtq_pkg::S_HEAD;
                end
            end
            sdtq_pkg::S_SVC_ERD:
            begin
                rd_idx     = k_reg[sdtq_pkg::ID_W-1:0];
                state_next = sdtq_pkg::S_SVC_EMIT;
            end
            sdtq_pkg::S_SVC_EMIT:
            begin
                rd_idx   = k_reg[sdtq_pkg::ID_W-1:0];
                ld_event = sdtq_pkg::EV_EXPIRED;
                ld_id    = rd_id;
                ld_due   = rd_data;
                ld_last  = (k_reg + sdtq_pkg::CNT_W'(1) == p_reg);
                if (out_free)
                begin
                    load   = 1'b1;
                    k_next = k_reg + sdtq_pkg::CNT_W'(1);
                    if (k_reg + sdtq_pkg::CNT_W'(1) == p_reg)
                    begin
                        state_next = sdtq_pkg::S_POP;
                    end
                    else
                    begin
                        state_next = sdtq_pkg::S_SVC_ERD;
                    end
                end
            end
            sdtq_pkg::S_POP:
            begin
                list_ctrl.op  = sdtq_pkg::LIST_REMOVE;
                list_ctrl.pos = '0;
                p_next        = p_reg - sdtq_pkg::CNT_W'(1);
                if (p_reg == sdtq_pkg::CNT_W'(1))
                begin
                    state_next = sdtq_pkg::S_IDLE;
                end
            end
            sdtq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = sdtq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sdtq_pkg::S_IDLE;
            end
        endcase

        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtq_pkg::S_IDLE;
            p_reg         <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            lead_reg      <= sdtq_pkg::LEAD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                lead_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        due_reg  <= due_next;
        now_reg  <= now_next;
        hd_reg   <= hd_next;
        duef_reg <= duef_next;
        ev_reg   <= ev_next;
        rdue_reg <= rdue_next;
        hv_reg   <= hv_next;
        hdue_reg <= hdue_next;
        if (load)
        begin
            res_event_reg <= ld_event;
            res_id_reg    <= ld_id;
            res_due_reg   <= ld_due;
            res_hv_reg    <= hv_reg;
            res_hdue_reg  <= hdue_reg;
            res_last_reg  <= ld_last;
        end
    end

    assign res_valid     = res_valid_reg;
    assign event_res     = res_event_reg;
    assign out_timer_id  = res_id_reg;
    assign out_due_tick  = res_due_reg;
    assign head_valid    = res_hv_reg;
    assign head_due_tick = res_hdue_reg;
    assign last          = res_last_reg;

`ifndef NO_ASSERTIONS
    a_no_req_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_last_reg) |-> req_stall)
        else $error("request accepted before the last result of a burst");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (list_ctrl.op == sdtq_pkg::LIST_INSERT) |-> (count < sdtq_pkg::NUM_TIMERS))
        else $error("insert into a full list");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (list_ctrl.op == sdtq_pkg::LIST_REMOVE) |-> (count != '0))
        else $error("remove from an empty list");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (list_ctrl.op == sdtq_pkg::LIST_NOP) |=> $stable(count))
        else $error("fill count changed without a list operation");
`endif

endmodule
